// File: src/lfu_page_replacement_defines.svh
// ----------------------------------------------------------------------------
// LFU page replacement: assertion macros
// Shared assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

`ifndef SYNTHESIS

// checked on every edge outside reset
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define LFU_ASSERT_NORST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_NORST(lbl, prop, msg)

`endif

`endif

// File: src/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU page replacement package
// Sizes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int NUM_PAGES  = 256;
    localparam int PAGE_W     = 8;
    localparam int MAX_FRAMES = 16;
    localparam int FRAME_W    = 4;
    localparam int FILL_W     = 5;
    localparam int CFG_W      = 5;
    localparam int COUNT_BITS = 16;
    localparam int TOTAL_W    = 32;

    localparam int IN_TDATA_W   = 8;
    localparam int OUT_FIELDS_W = 1 + FRAME_W + 1 + PAGE_W + 2 * TOTAL_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(MAX_FRAMES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_SCAN,
        ST_UPDATE
    } lfu_state_t;

    typedef struct packed {
        logic load;        // latch the requested page
        logic lookup;      // read frame and count of the page
        logic capture;     // hold lookup results
        logic scan_start;  // begin minimum-count search
        logic commit;      // write tables, load result register
    } lfu_cmd_t;

    typedef struct packed {
        logic hit;
        logic fill_avail;
        logic scan_done;
        logic out_free;
    } lfu_stat_t;

endpackage

// File: src/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU controller
// Sequences lookup, victim search and table update for one item at a time.
// ----------------------------------------------------------------------------
module lfu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_cmd_t  cmd
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.capture = 1'b1;
                if (stat.hit || stat.fill_avail) begin
                    state_next = ST_UPDATE;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // wait for the result register to free up
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/lfu_datapath.sv
// ----------------------------------------------------------------------------
// LFU datapath
// Page and frame tables, access counts, victim search pipeline, result register.
// ----------------------------------------------------------------------------
`include "lfu_page_replacement_defines.svh"

module lfu_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lfu_pkg::lfu_cmd_t                 cmd,
    output lfu_pkg::lfu_stat_t                stat,
    input  logic [lfu_pkg::PAGE_W-1:0]        s_page,
    input  logic                              cfg_valid,
    input  logic [lfu_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic                              o_hit,
    output logic [lfu_pkg::FRAME_W-1:0]       o_frame,
    output logic                              o_ev_valid,
    output logic [lfu_pkg::PAGE_W-1:0]        o_ev_page,
    output logic [lfu_pkg::TOTAL_W-1:0]       o_hit_total,
    output logic [lfu_pkg::TOTAL_W-1:0]       o_miss_total
);
    import lfu_pkg::*;

    // configuration and request
    logic [CFG_W-1:0]   frames_reg;
    logic [FILL_W-1:0]  lim;
    logic [PAGE_W-1:0]  pg_reg;

    // per-page flags, cleared at reset
    logic [NUM_PAGES-1:0] resident_reg;
    logic [NUM_PAGES-1:0] count_valid_reg;
    logic                 res_rdata_reg;

    // memories
    logic [FRAME_W-1:0]    pf_mem  [NUM_PAGES];
    logic [PAGE_W-1:0]     fp_mem  [MAX_FRAMES];
    logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
    logic [FRAME_W-1:0]    pf_rdata_reg;
    logic [PAGE_W-1:0]     fp_rdata_reg;
    logic [COUNT_BITS-1:0] cnt_rdata_reg;
    logic                  cv_rdata_reg;
    logic [COUNT_BITS-1:0] cnt_val;
    logic                  cnt_rd_en;
    logic [PAGE_W-1:0]     cnt_rd_addr;

    // policy state
    logic [FILL_W-1:0]  fill_reg;
    logic [TOTAL_W-1:0] hit_total_reg;
    logic [TOTAL_W-1:0] miss_total_reg;
    logic [TOTAL_W-1:0] hit_total_next;
    logic [TOTAL_W-1:0] miss_total_next;

    // captured lookup results
    logic                  hit_cap_reg;
    logic                  fill_cap_reg;
    logic [FRAME_W-1:0]    pf_cap_reg;
    logic [COUNT_BITS-1:0] pg_cnt_reg;

    // victim search pipeline
    logic                  scan_active_reg;
    logic [FILL_W-1:0]     scan_idx_reg;
    logic                  scan_issue;
    logic                  s1_valid_reg;
    logic [FRAME_W-1:0]    s1_idx_reg;
    logic                  s2_valid_reg;
    logic [FRAME_W-1:0]    s2_idx_reg;
    logic [PAGE_W-1:0]     s2_page_reg;
    logic                  best_valid_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic [FRAME_W-1:0]    best_frame_reg;
    logic [PAGE_W-1:0]     best_page_reg;
    logic                  better;
    logic                  scan_done;

    // commit values
    logic [FRAME_W-1:0]    frame_sel;
    logic                  miss;
    logic                  evict;
    logic [COUNT_BITS-1:0] cnt_inc;

    // result register
    logic                  m_valid_reg;
    logic                  o_hit_reg;
    logic [FRAME_W-1:0]    o_frame_reg;
    logic                  o_ev_valid_reg;
    logic [PAGE_W-1:0]     o_ev_page_reg;

    always_comb begin
        if (frames_reg == '0) begin
            lim = FILL_W'(1);
        end else if (frames_reg > CFG_W'(MAX_FRAMES)) begin
            lim = FILL_W'(MAX_FRAMES);
        end else begin
            lim = FILL_W'(frames_reg);
        end
    end

    assign cnt_val     = cv_rdata_reg ? cnt_rdata_reg : '0;
    assign cnt_rd_en   = cmd.lookup || s1_valid_reg;
    assign cnt_rd_addr = s1_valid_reg ? fp_rdata_reg : pg_reg;
    assign scan_issue  = scan_active_reg && (scan_idx_reg < lim);
    assign scan_done   = scan_active_reg && !scan_issue && !s1_valid_reg && !s2_valid_reg;
    assign better      = s2_valid_reg && (!best_valid_reg || (cnt_val < best_cnt_reg));

    assign miss      = !hit_cap_reg;
    assign evict     = miss && !fill_cap_reg;
    assign frame_sel = hit_cap_reg  ? pf_cap_reg :
                       fill_cap_reg ? fill_reg[FRAME_W-1:0] : best_frame_reg;
    assign cnt_inc   = (pg_cnt_reg == '1) ? pg_cnt_reg : pg_cnt_reg + COUNT_BITS'(1);

    assign hit_total_next  = (hit_cap_reg && hit_total_reg != '1) ?
                             hit_total_reg + TOTAL_W'(1) : hit_total_reg;
    assign miss_total_next = (miss && miss_total_reg != '1) ?
                             miss_total_reg + TOTAL_W'(1) : miss_total_reg;

    assign stat.hit        = res_rdata_reg;
    assign stat.fill_avail = fill_reg < lim;
    assign stat.scan_done  = scan_done;
    assign stat.out_free   = !m_valid_reg || m_ready;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg      <= FRAMES_RESET;
            resident_reg    <= '0;
            count_valid_reg <= '0;
            fill_reg        <= '0;
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            scan_active_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            best_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                frames_reg <= cfg_data;
            end
            if (cmd.scan_start) begin
                scan_active_reg <= 1'b1;
                best_valid_reg  <= 1'b0;
            end else begin
                if (scan_done) begin
                    scan_active_reg <= 1'b0;
                end
                if (better) begin
                    best_valid_reg <= 1'b1;
                end
            end
            s1_valid_reg <= scan_issue;
            s2_valid_reg <= s1_valid_reg;
            if (cmd.commit) begin
                hit_total_reg            <= hit_total_next;
                miss_total_reg           <= miss_total_next;
                count_valid_reg[pg_reg]  <= 1'b1;
                if (miss) begin
                    resident_reg[pg_reg] <= 1'b1;
                end
                if (evict) begin
                    resident_reg[best_page_reg] <= 1'b0;
                end
                if (miss && fill_cap_reg) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pg_reg <= s_page;
        end
        if (cmd.lookup) begin
            res_rdata_reg <= resident_reg[pg_reg];
        end
        if (cmd.capture) begin
            hit_cap_reg  <= res_rdata_reg;
            fill_cap_reg <= fill_reg < lim;
            pf_cap_reg   <= pf_rdata_reg;
            pg_cnt_reg   <= cnt_val;
        end
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
        end else if (scan_issue) begin
            scan_idx_reg <= scan_idx_reg + FILL_W'(1);
        end
        s1_idx_reg  <= scan_idx_reg[FRAME_W-1:0];
        s2_idx_reg  <= s1_idx_reg;
        s2_page_reg <= fp_rdata_reg;
        // strict compare keeps the lowest frame on ties
        if (better) begin
            best_cnt_reg   <= cnt_val;
            best_frame_reg <= s2_idx_reg;
            best_page_reg  <= s2_page_reg;
        end
        if (cmd.commit) begin
            o_hit_reg      <= hit_cap_reg;
            o_frame_reg    <= frame_sel;
            o_ev_valid_reg <= evict;
            o_ev_page_reg  <= evict ? best_page_reg : '0;
        end
    end

    // page -> frame table
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            pf_rdata_reg <= pf_mem[pg_reg];
        end
        if (cmd.commit && miss) begin
            pf_mem[pg_reg] <= frame_sel;
        end
    end

    // frame -> page table
    always_ff @(posedge aclk) begin
        if (scan_issue) begin
            fp_rdata_reg <= fp_mem[scan_idx_reg[FRAME_W-1:0]];
        end
        if (cmd.commit && miss) begin
            fp_mem[frame_sel] <= pg_reg;
        end
    end

    // access counts; an entry without its valid flag reads as zero
    always_ff @(posedge aclk) begin
        if (cnt_rd_en) begin
            cnt_rdata_reg <= cnt_mem[cnt_rd_addr];
            cv_rdata_reg  <= count_valid_reg[cnt_rd_addr];
        end
        if (cmd.commit) begin
            cnt_mem[pg_reg] <= cnt_inc;
        end
    end

    assign m_valid      = m_valid_reg;
    assign o_hit        = o_hit_reg;
    assign o_frame      = o_frame_reg;
    assign o_ev_valid   = o_ev_valid_reg;
    assign o_ev_page    = o_ev_page_reg;
    assign o_hit_total  = hit_total_reg;
    assign o_miss_total = miss_total_reg;

    `LFU_ASSERT(a_victim_resident, cmd.commit && evict |-> resident_reg[best_page_reg], "evicting a page that is not resident")
    `LFU_ASSERT(a_scan_found, scan_done |-> best_valid_reg, "victim search ended without a candidate")
    `LFU_ASSERT(a_commit_result, cmd.commit |=> m_valid_reg, "commit did not load the result register")
    `LFU_ASSERT_NORST(a_reset_empty, !aresetn |=> !m_valid_reg && !scan_active_reg, "reset left work pending")

endmodule

// File: src/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// LFU page replacement
// Page residency lookup with least-frequently-used eviction.
// ----------------------------------------------------------------------------
// One request is worked at a time. A hit, or a miss that fills a free frame,
// goes through lookup and decide to update, which loads the result register
// once it is free; the next request is taken in the cycle after that. A miss
// with all usable frames full first runs a victim search, which walks the
// frame table one frame per cycle through a two-stage read pipeline (frame
// table, then count memory). A new request is taken while the previous
// result still waits on m_tvalid. The count store needs no clearing pass:
// per-page valid flags cleared at reset make unwritten counts read as zero.
// frames_in_use is clamped to 1..16; write it only while the block is idle.
module lfu_page_replacement (
    input  logic        aclk,
    input  logic        aresetn,
    // config: frames_in_use
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,      // [4:0] frames_in_use
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] page
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata        // [0] hit, [4:1] frame, [5] evicted_valid,
                                       // [13:6] evicted_page, [45:14] hit_total,
                                       // [77:46] miss_total, [79:78] zero
);
    import lfu_pkg::*;

    lfu_cmd_t            cmd;
    lfu_stat_t           stat;
    logic                o_hit;
    logic [FRAME_W-1:0]  o_frame;
    logic                o_ev_valid;
    logic [PAGE_W-1:0]   o_ev_page;
    logic [TOTAL_W-1:0]  o_hit_total;
    logic [TOTAL_W-1:0]  o_miss_total;

    assign cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lfu_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_page       (s_tdata[PAGE_W-1:0]),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .m_ready      (m_tready),
        .m_valid      (m_tvalid),
        .o_hit        (o_hit),
        .o_frame      (o_frame),
        .o_ev_valid   (o_ev_valid),
        .o_ev_page    (o_ev_page),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, o_miss_total, o_hit_total,
                      o_ev_page, o_ev_valid, o_frame, o_hit};

endmodule

// File: verif/lfu_page_replacement_checker.sv
// ----------------------------------------------------------------------------
// LFU page replacement: result checker
// Watches the config, request and result streams, keeps its own copy of the
// residency tables and access counts, and compares every result item field by
// field with the oldest predicted one.
// ----------------------------------------------------------------------------
module lfu_page_replacement_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [lfu_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [lfu_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              fail_count,
    output int                              expected_left,
    output int                              hits_checked,
    output int                              misses_checked,
    output int                              evictions_checked
);
    import lfu_pkg::*;

    // lowest bit last, so the cast from m_tdata lines up with the port layout
    typedef struct packed {
        logic [TOTAL_W-1:0] miss_total;
        logic [TOTAL_W-1:0] hit_total;
        logic [PAGE_W-1:0]  evicted_page;
        logic               evicted_valid;
        logic [FRAME_W-1:0] frame;
        logic               hit;
    } lfu_result_t;

    logic                  resident     [NUM_PAGES];
    logic [FRAME_W-1:0]    page_frame   [NUM_PAGES];
    logic [PAGE_W-1:0]     frame_page   [MAX_FRAMES];
    logic [COUNT_BITS-1:0] access_count [NUM_PAGES];
    logic [FILL_W-1:0]     frames_filled;
    logic [TOTAL_W-1:0]    hits_so_far;
    logic [TOTAL_W-1:0]    misses_so_far;
    logic [CFG_W-1:0]      frame_limit;

    lfu_result_t expected_results [$];
    int          results_seen;

    // Resolve one request against the tables and update them.
    function automatic lfu_result_t lookup_page(input logic [PAGE_W-1:0] pg);
        lfu_result_t           r;
        logic [FILL_W-1:0]     usable;
        logic [COUNT_BITS:0]   best;
        r = '0;
        if (frame_limit == 0)
            usable = FILL_W'(1);
        else if (frame_limit > MAX_FRAMES)
            usable = FILL_W'(MAX_FRAMES);
        else
            usable = frame_limit;

        if (resident[pg]) begin
            r.hit = 1'b1;
            r.frame = page_frame[pg];
            if (hits_so_far != '1)
                hits_so_far++;
        end else begin
            if (misses_so_far != '1)
                misses_so_far++;
            if (frames_filled < usable) begin
                r.frame = frames_filled[FRAME_W-1:0];
                frames_filled++;
            end else begin
                // smallest count wins, strict compare keeps the lowest frame on ties;
                // frames at or above a lowered limit are never candidates
                best = '1;
                for (int i = 0; i < usable; i++) begin
                    if ({1'b0, access_count[frame_page[i]]} < best) begin
                        best = {1'b0, access_count[frame_page[i]]};
                        r.frame = FRAME_W'(i);
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page = frame_page[r.frame];
                resident[r.evicted_page] = 1'b0;
            end
            frame_page[r.frame] = pg;
            page_frame[pg] = r.frame;
            resident[pg] = 1'b1;
        end
        if (access_count[pg] != '1)
            access_count[pg]++;
        r.hit_total = hits_so_far;
        r.miss_total = misses_so_far;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 10)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        lfu_result_t want;
        lfu_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_PAGES; i++) begin
                resident[i] = 1'b0;
                access_count[i] = '0;
            end
            frames_filled = '0;
            hits_so_far = '0;
            misses_so_far = '0;
            frame_limit = FRAMES_RESET;
            expected_results.delete();
            fail_count = 0;
            hits_checked = 0;
            misses_checked = 0;
            evictions_checked = 0;
            results_seen = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = lfu_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d: unexpected item %0h", results_seen, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", TOTAL_W'(want.hit), TOTAL_W'(got.hit));
                    check_field("frame", TOTAL_W'(want.frame), TOTAL_W'(got.frame));
                    check_field("evicted_valid", TOTAL_W'(want.evicted_valid),
                                TOTAL_W'(got.evicted_valid));
                    check_field("evicted_page", TOTAL_W'(want.evicted_page),
                                TOTAL_W'(got.evicted_page));
                    check_field("hit_total", want.hit_total, got.hit_total);
                    check_field("miss_total", want.miss_total, got.miss_total);
                    if (want.hit)
                        hits_checked++;
                    else
                        misses_checked++;
                    if (want.evicted_valid)
                        evictions_checked++;
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                frame_limit = cfg_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(lookup_page(s_tdata));
        end
        expected_left = expected_results.size();
    end

endmodule

// File: verif/tb_lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// LFU page replacement testbench
// Directed fills, hits and evictions, then random page streams with working
// sets and hot pages across many frame limits, with random idling on both
// streams and one long result hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_lfu_page_replacement;
    import lfu_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASE_ITEMS     = 70;
    localparam int DRAIN_CYCLES    = 40;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;      // [7:0] page
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;      // [0] hit, [4:1] frame, [5] evicted_valid,
                                          // [13:6] evicted_page, [45:14] hit_total,
                                          // [77:46] miss_total, [79:78] zero

    int fail_count;
    int expected_left;
    int hits_checked;
    int misses_checked;
    int evictions_checked;

    logic              quiet;             // no idling on either side
    logic              hold_off_req;      // asks the receiver for one long hold-off
    logic              hold_off_done;     // receiver has finished it
    int                pages_sent;
    int                limits_run;
    int                idle_cycles;
    logic [PAGE_W-1:0] ws_base;
    int                ws_size;
    logic [PAGE_W-1:0] hot_pages [3];

    lfu_page_replacement dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lfu_page_replacement_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .fail_count        (fail_count),
        .expected_left     (expected_left),
        .hits_checked      (hits_checked),
        .misses_checked    (misses_checked),
        .evictions_checked (evictions_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int n;
        m_tready = 1'b0;
        hold_off_done = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("no progress for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, expected_left);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Called at a falling edge; leaves tvalid high unless an idle burst follows.
    task automatic send_page(input logic [PAGE_W-1:0] pg);
        int n;
        s_tvalid <= 1'b1;
        s_tdata <= pg;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        pages_sent++;
        if (!quiet && !(hold_off_req && !hold_off_done) && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            s_tdata <= PAGE_W'($urandom);
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_left != 0) @(negedge aclk);
    endtask

    task automatic set_frame_limit(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        limits_run++;
    endtask

    // mostly a working set a bit larger than the frames, some hot pages, some noise
    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
        else if (r < 35)
            return hot_pages[$urandom_range(0, 2)];
        else
            return ws_base + PAGE_W'($urandom_range(0, ws_size - 1));
    endfunction

    initial begin
        logic [PAGE_W-1:0] directed_pages [$];
        logic [CFG_W-1:0]  limit_plan [$];
        int                usable;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        quiet = 1'b0;
        hold_off_req = 1'b0;
        pages_sent = 0;
        limits_run = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill all 16 frames with uneven counts, then force two evictions
        directed_pages = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4,
                           8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
                           8'd14, 8'd128, 8'd1};
        set_frame_limit(5'd16);
        foreach (directed_pages[i])
            send_page(directed_pages[i]);
        // lowered limit: page in a high frame still hits, victims only below 4
        set_frame_limit(5'd4);
        send_page(8'd14);
        send_page(8'd200);
        // zero acts as one frame
        set_frame_limit(5'd0);
        send_page(8'd77);
        send_page(8'd78);
        // above the maximum clamps to 16
        set_frame_limit(5'd31);
        send_page(8'd90);

        limit_plan = '{5'd1, 5'd16, 5'd3, 5'd8, 5'd31, 5'd0, 5'd12, 5'd16, 5'd5, 5'd2,
                       5'd7, 5'd16};
        foreach (limit_plan[p]) begin
            set_frame_limit(limit_plan[p]);
            quiet = (p >= limit_plan.size() - 2);
            usable = (limit_plan[p] == 0) ? 1 :
                     (limit_plan[p] > MAX_FRAMES) ? MAX_FRAMES : int'(limit_plan[p]);
            ws_base = PAGE_W'($urandom);
            ws_size = usable + $urandom_range(1, usable + 4);
            foreach (hot_pages[h])
                hot_pages[h] = ws_base + PAGE_W'($urandom_range(0, ws_size - 1));
            if (p == 1)
                hold_off_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_page(pick_page());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d page requests under %0d frame-limit writes (0, 1, 16, 31 included)",
                 pages_sent, limits_run);
        $display("Checked %0d hits, %0d misses, %0d evictions",
                 hits_checked, misses_checked, evictions_checked);
        if (fail_count == 0 && expected_left == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, expected_left);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
